>>> rtl/pckr_pkg.sv
// Shared types and constants of the color-key recolor pipeline.
package pckr_pkg;

   localparam int NumRefs     = 4;
   localparam int RefWidth    = 33;
   localparam int CsrWidth    = 33;
   localparam int IndexWidth  = 3;
   localparam int ChanWidth   = 8;
   localparam int LevelWidth  = 9;
   localparam int PqWidth     = 17;
   localparam int NumWidth    = 22;
   localparam int YWidth      = 14;

   localparam logic [7:0] Tolerance = 8'd24;
   localparam logic [29:0] RoundHalf = 30'd1966080;
   localparam logic [14:0] RecipMul = 15'd17477;

   typedef enum logic [IndexWidth-1:0] {
      RegRefColor0 = 3'd0,
      RegRefColor1 = 3'd1,
      RegRefColor2 = 3'd2,
      RegRefColor3 = 3'd3,
      RegRefCount  = 3'd4,
      RegTargetHue = 3'd5,
      RegTargetSat = 3'd6,
      RegTargetVal = 3'd7
   } reg_index_type;

   localparam logic [RefWidth-1:0] RefReset0 = 33'h100B8F818;
   localparam logic [RefWidth-1:0] RefReset1 = 33'h0B358A858;
   localparam logic [RefWidth-1:0] RefReset2 = 33'h066386838;
   localparam logic [RefWidth-1:0] RefReset3 = 33'h026183818;

   typedef struct packed {
      logic [NumRefs-1:0][RefWidth-1:0] ref_color;
      logic [NumRefs-1:0]               ref_en;
      logic [LevelWidth-1:0]            sat;
      logic [LevelWidth-1:0]            val;
   } cfg_type;

   typedef struct packed {
      logic [31:0] pixel;
      logic        hit;
   } side_type;

   typedef struct packed {
      logic                 gray;
      logic [ChanWidth-1:0] level;
   } gray_type;

   typedef struct packed {
      logic load_a;
      logic load_b;
   } stage_en_type;

endpackage

>>> rtl/pckr_match.sv
// Stage one: compares a pixel with the active references and picks the first match.
module pckr_match (
   input  logic                              clock,
   input  logic                              load,
   input  pckr_pkg::cfg_type                 cfg,
   input  logic [31:0]                       pixel,
   output pckr_pkg::side_type                side_ff,
   output logic [pckr_pkg::LevelWidth-1:0]   refl_ff
);
   import pckr_pkg::*;

   logic [NumRefs-1:0] match;
   logic [1:0]         hit_idx;
   logic               hit_any;
   side_type           side_in;
   logic [LevelWidth-1:0] refl_in;

   function automatic logic near(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] diff;
      diff = (a > b) ? a - b : b - a;
      return diff <= Tolerance;
   endfunction

   always_comb begin
      for (int i = 0; i < NumRefs; i++) begin
         match[i] = cfg.ref_en[i] &&
                    near(pixel[23:16], cfg.ref_color[i][23:16]) &&
                    near(pixel[15:8], cfg.ref_color[i][15:8]) &&
                    near(pixel[7:0], cfg.ref_color[i][7:0]);
      end
      hit_any = |match;
      hit_idx = 2'd0;
      for (int i = NumRefs - 1; i >= 0; i--) begin
         if (match[i]) begin
            hit_idx = 2'(i);
         end
      end
      side_in.pixel = pixel;
      side_in.hit   = hit_any;
      refl_in       = cfg.ref_color[hit_idx][32:24];
   end

   always_ff @(posedge clock) begin
      if (load) begin
         side_ff <= side_in;
         refl_ff <= refl_in;
      end
   end

endmodule

>>> rtl/pckr_light.sv
// Stages two and three: scaled lightness, then the HSL P and Q levels and the grey case.
module pckr_light (
   input  logic                              clock,
   input  pckr_pkg::stage_en_type            en,
   input  pckr_pkg::cfg_type                 cfg,
   input  logic [pckr_pkg::LevelWidth-1:0]   refl,
   output logic [pckr_pkg::PqWidth-1:0]      p_ff,
   output logic [pckr_pkg::PqWidth-1:0]      q_ff,
   output pckr_pkg::gray_type                gray_ff
);
   import pckr_pkg::*;

   logic [18:0]           lprod;
   logic [10:0]           lsh;
   logic [LevelWidth-1:0] l_in;
   logic [LevelWidth-1:0] l_ff;
   logic                  low;
   logic [8:0]            mul_a;
   logic [9:0]            mul_b;
   logic [18:0]           prod;
   logic [PqWidth-1:0]    q_in;
   logic [PqWidth-1:0]    p_in;
   gray_type              gray_in;

   always_comb begin
      lprod = 19'(refl) * 19'(cfg.val) + 19'd128;
      lsh   = lprod[18:8];
      l_in  = (lsh > 11'd256) ? 9'd256 : lsh[8:0];
   end

   always_comb begin
      low   = l_ff < 9'd128;
      mul_a = low ? l_ff : 9'd256 - l_ff;
      mul_b = low ? 10'd256 + 10'(cfg.sat) : 10'd256 - 10'(cfg.sat);
      prod  = 19'(mul_a) * 19'(mul_b);
      q_in  = low ? prod[16:0] : 17'(18'd65536 - prod[17:0]);
      p_in  = 17'({l_ff, 9'b0} - 18'(q_in));
      gray_in.gray  = cfg.sat == 9'd0;
      gray_in.level = (l_ff == 9'd0) ? 8'd0 : 8'(l_ff - 9'd1);
   end

   always_ff @(posedge clock) begin
      if (en.load_a) begin
         l_ff <= l_in;
      end
      if (en.load_b) begin
         p_ff    <= p_in;
         q_ff    <= q_in;
         gray_ff <= gray_in;
      end
   end

endmodule

>>> rtl/pckr_chan.sv
// Stages four and five of one color channel: hue ramp blend and scaling toward eight bits.
module pckr_chan (
   input  logic                              clock,
   input  pckr_pkg::stage_en_type            en,
   input  logic [8:0]                        hue_t,
   input  logic [pckr_pkg::PqWidth-1:0]      p,
   input  logic [pckr_pkg::PqWidth-1:0]      q,
   output logic [pckr_pkg::YWidth-1:0]       y_ff
);
   import pckr_pkg::*;

   logic [5:0]          w;
   logic [PqWidth-1:0]  d;
   logic [22:0]         p60;
   logic [22:0]         dw;
   logic [NumWidth-1:0] num_in;
   logic [NumWidth-1:0] num_ff;
   logic [29:0]         x;
   logic [YWidth-1:0]   y_in;

   always_comb begin
      if (hue_t < 9'd60) begin
         w = hue_t[5:0];
      end else if (hue_t < 9'd180) begin
         w = 6'd60;
      end else if (hue_t < 9'd240) begin
         w = 6'(9'd240 - hue_t);
      end else begin
         w = 6'd0;
      end
      d      = q - p;
      p60    = {p, 6'b0} - {4'b0, p, 2'b0};
      dw     = 23'(d) * 23'(w);
      num_in = 22'(p60 + dw);
   end

   always_comb begin
      x    = {num_ff, 8'b0} - 30'(num_ff) + RoundHalf;
      y_in = x[29:16];
   end

   always_ff @(posedge clock) begin
      if (en.load_a) begin
         num_ff <= num_in;
      end
      if (en.load_b) begin
         y_ff <= y_in;
      end
   end

endmodule

>>> rtl/pixel_color_key_hsl_recolor.sv
// Top level of the color-key recolor pipeline: registers, flow control and output stage.
//
//   channel   direction  ports                               accepted when
//   req       in         req_valid req_stall req_pixel_in    req_valid && !req_stall
//   rsp       out        rsp_valid rsp_stall rsp_pixel_out   rsp_valid && !rsp_stall
//                        rsp_recolored
//   csr       in         csr_wr_en csr_index csr_wdata       csr_wr_en && !reset
//
// One item enters per cycle while req_stall is low; an accepted item passes through the stage
// registers in order and can leave on rsp once it is in the output register.
// The six stages are match, lightness, P and Q, channel blend, scaling, and the reciprocal
// multiply into the output register. Synchronous reset empties the pipeline and loads the
// register defaults. A stall on rsp holds the output; empty stages behind it still fill.
module pixel_color_key_hsl_recolor (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [31:0]                       req_pixel_in,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [31:0]                       rsp_pixel_out,
   output logic                              rsp_recolored,
   input  logic                              csr_wr_en,
   input  logic [pckr_pkg::IndexWidth-1:0]   csr_index,
   input  logic [pckr_pkg::CsrWidth-1:0]     csr_wdata
);
   import pckr_pkg::*;

   logic [NumRefs-1:0][RefWidth-1:0] ref_color_ff;
   logic [2:0]            ref_count_ff;
   logic [8:0]            target_hue_ff;
   logic [8:0]            target_sat_ff;
   logic [8:0]            target_val_ff;

   cfg_type               cfg;
   logic [8:0]            hue;
   logic [9:0]            hsum_r;
   logic [9:0]            hsum_b;
   logic [8:0]            t_r;
   logic [8:0]            t_b;
   logic                  window;
   logic [2:0]            cnt;

   logic [6:1]            v_ff;
   logic [6:1]            v_in;
   logic [6:1]            en;

   side_type              side1;
   logic [LevelWidth-1:0] refl1;
   side_type              side2_ff;
   side_type              side3_ff;
   side_type              side4_ff;
   side_type              side5_ff;
   gray_type              gray3;
   gray_type              gray4_ff;
   gray_type              gray5_ff;
   logic [PqWidth-1:0]    p3;
   logic [PqWidth-1:0]    q3;
   logic [YWidth-1:0]     y_r;
   logic [YWidth-1:0]     y_g;
   logic [YWidth-1:0]     y_b;
   logic [28:0]           prod_r;
   logic [28:0]           prod_g;
   logic [28:0]           prod_b;
   logic [31:0]           pixel_out_in;
   logic [31:0]           pixel_out_ff;
   logic                  recolored_ff;
   stage_en_type          light_en;
   stage_en_type          chan_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_color_ff[0] <= RefReset0;
         ref_color_ff[1] <= RefReset1;
         ref_color_ff[2] <= RefReset2;
         ref_color_ff[3] <= RefReset3;
         ref_count_ff    <= 3'd0;
         target_hue_ff   <= 9'd120;
         target_sat_ff   <= 9'd204;
         target_val_ff   <= 9'd256;
      end else if (csr_wr_en) begin
         case (reg_index_type'(csr_index))
            RegRefColor0: ref_color_ff[0] <= csr_wdata;
            RegRefColor1: ref_color_ff[1] <= csr_wdata;
            RegRefColor2: ref_color_ff[2] <= csr_wdata;
            RegRefColor3: ref_color_ff[3] <= csr_wdata;
            RegRefCount:  ref_count_ff    <= csr_wdata[2:0];
            RegTargetHue: target_hue_ff   <= csr_wdata[8:0];
            RegTargetSat: target_sat_ff   <= csr_wdata[8:0];
            RegTargetVal: target_val_ff   <= csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      hue    = (target_hue_ff >= 9'd360) ? target_hue_ff - 9'd360 : target_hue_ff;
      hsum_r = {1'b0, hue} + 10'd120;
      hsum_b = {1'b0, hue} + 10'd240;
      t_r    = (hsum_r >= 10'd360) ? 9'(hsum_r - 10'd360) : hsum_r[8:0];
      t_b    = (hsum_b >= 10'd360) ? 9'(hsum_b - 10'd360) : hsum_b[8:0];
      window = hue >= 9'd111 && hue <= 9'd129 &&
               target_sat_ff >= 9'd180 && target_sat_ff <= 9'd230;
      cnt    = (ref_count_ff > 3'd4) ? 3'd4 : ref_count_ff;
      cfg.ref_color = ref_color_ff;
      for (int i = 0; i < NumRefs; i++) begin
         cfg.ref_en[i] = !window && (3'(i) < cnt);
      end
      cfg.sat = (target_sat_ff > 9'd256) ? 9'd256 : target_sat_ff;
      cfg.val = target_val_ff;
   end

   // A stage loads when it is empty or when the stage after it moves on.
   always_comb begin
      en[6] = !v_ff[6] || !rsp_stall;
      for (int k = 5; k >= 1; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
      v_in[1] = req_valid;
      for (int k = 2; k <= 6; k++) begin
         v_in[k] = v_ff[k-1];
      end
      req_stall = reset || !en[1];
      light_en.load_a = en[2];
      light_en.load_b = en[3];
      chan_en.load_a  = en[4];
      chan_en.load_b  = en[5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 1; k <= 6; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_in[k];
            end
         end
      end
   end

   pckr_match u_match (
      .clock   (clock),
      .load    (en[1]),
      .cfg     (cfg),
      .pixel   (req_pixel_in),
      .side_ff (side1),
      .refl_ff (refl1)
   );

   pckr_light u_light (
      .clock   (clock),
      .en      (light_en),
      .cfg     (cfg),
      .refl    (refl1),
      .p_ff    (p3),
      .q_ff    (q3),
      .gray_ff (gray3)
   );

   pckr_chan u_chan_r (
      .clock (clock),
      .en    (chan_en),
      .hue_t (t_r),
      .p     (p3),
      .q     (q3),
      .y_ff  (y_r)
   );

   pckr_chan u_chan_g (
      .clock (clock),
      .en    (chan_en),
      .hue_t (hue),
      .p     (p3),
      .q     (q3),
      .y_ff  (y_g)
   );

   pckr_chan u_chan_b (
      .clock (clock),
      .en    (chan_en),
      .hue_t (t_b),
      .p     (p3),
      .q     (q3),
      .y_ff  (y_b)
   );

   always_ff @(posedge clock) begin
      if (en[2]) begin
         side2_ff <= side1;
      end
      if (en[3]) begin
         side3_ff <= side2_ff;
      end
      if (en[4]) begin
         side4_ff <= side3_ff;
         gray4_ff <= gray3;
      end
      if (en[5]) begin
         side5_ff <= side4_ff;
         gray5_ff <= gray4_ff;
      end
   end

   always_comb begin
      prod_r = 29'(y_r) * 29'(RecipMul);
      prod_g = 29'(y_g) * 29'(RecipMul);
      prod_b = 29'(y_b) * 29'(RecipMul);
      if (!side5_ff.hit) begin
         pixel_out_in = side5_ff.pixel;
      end else if (gray5_ff.gray) begin
         pixel_out_in = {side5_ff.pixel[31:24], gray5_ff.level, gray5_ff.level,
                         gray5_ff.level};
      end else begin
         pixel_out_in = {side5_ff.pixel[31:24], prod_r[27:20], prod_g[27:20],
                         prod_b[27:20]};
      end
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         pixel_out_ff <= pixel_out_in;
         recolored_ff <= side5_ff.hit;
      end
   end

   assign rsp_valid     = v_ff[6];
   assign rsp_pixel_out = pixel_out_ff;
   assign rsp_recolored = recolored_ff;

endmodule

>>> rtl/pckr_check.sv
// Port-level checks of the recolor pipeline and their binding to the top level.
module pckr_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [31:0] req_pixel_in,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_pixel_out,
   input logic        rsp_recolored
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Output is valid right after reset.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=>
         rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_recolored))
      else $error("Stalled output item changed or vanished.");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("Accepted item did not reach the output in six cycles.");

   a_alpha: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
         ##1 !rsp_stall ##1 !rsp_stall |=>
         rsp_pixel_out[31:24] == $past(req_pixel_in[31:24], 6))
      else $error("Alpha of an item was not kept.");

endmodule

bind pixel_color_key_hsl_recolor pckr_check u_pckr_check (.*);

>>> tb/testbench.sv
// Self-checking testbench for the color-key recolor pipeline, with its own recolor predictor.
module testbench;
   import pckr_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [31:0] req_pixel_in = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_pixel_out;
   logic        rsp_recolored;
   logic        csr_wr_en = 1'b0;
   logic [IndexWidth-1:0] csr_index = '0;
   logic [CsrWidth-1:0]   csr_wdata = '0;

   logic [RefWidth-1:0] key_ref [NumRefs];
   logic [2:0]          key_count;
   logic [8:0]          hue_reg;
   logic [8:0]          sat_reg;
   logic [8:0]          val_reg;

   side_type expected_pixels [$];
   int       error_count = 0;
   int       cycle_count = 0;
   int       stall_left = 0;
   bit       idle_enable = 1'b1;

   pixel_color_key_hsl_recolor dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_pixel_in(req_pixel_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_out(rsp_pixel_out),
      .rsp_recolored(rsp_recolored),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic logic [7:0] blend_channel(longint unsigned p, longint unsigned q,
                                                longint unsigned t);
      longint unsigned num;
      if (t < 60)
         num = p * 60 + (q - p) * t;
      else if (t < 180)
         num = q * 60;
      else if (t < 240)
         num = p * 60 + (q - p) * (240 - t);
      else
         num = p * 60;
      return 8'((num * 255 + 60 * 32768) / (60 * 65536));
   endfunction

   function automatic side_type predict_recolor(logic [31:0] pix);
      side_type        res;
      longint unsigned hue, cnt, light, sat, p, q;
      logic [7:0]      level;
      int              hit;
      res.pixel = pix;
      res.hit = 1'b0;
      hue = hue_reg % 360;
      cnt = (key_count > NumRefs) ? NumRefs : key_count;
      hit = -1;
      if (cnt == 0 || (hue >= 111 && hue <= 129 && sat_reg >= 180 && sat_reg <= 230))
         return res;
      for (int i = 0; i < cnt; i++) begin
         if (hit < 0 &&
             (pix[23:16] > key_ref[i][23:16] ? pix[23:16] - key_ref[i][23:16]
                                             : key_ref[i][23:16] - pix[23:16]) <= Tolerance &&
             (pix[15:8] > key_ref[i][15:8] ? pix[15:8] - key_ref[i][15:8]
                                           : key_ref[i][15:8] - pix[15:8]) <= Tolerance &&
             (pix[7:0] > key_ref[i][7:0] ? pix[7:0] - key_ref[i][7:0]
                                         : key_ref[i][7:0] - pix[7:0]) <= Tolerance) begin
            hit = i;
         end
      end
      if (hit < 0)
         return res;
      light = (longint'(key_ref[hit][32:24]) * val_reg + 128) >> 8;
      if (light > 256)
         light = 256;
      sat = (sat_reg > 256) ? 256 : sat_reg;
      res.hit = 1'b1;
      if (sat == 0) begin
         level = 8'((light * 255) >> 8);
         res.pixel = {pix[31:24], level, level, level};
      end else begin
         if (light < 128)
            q = light * (256 + sat);
         else
            q = 65536 - (256 - light) * (256 - sat);
         p = 512 * light - q;
         res.pixel = {pix[31:24], blend_channel(p, q, (hue + 120) % 360),
                      blend_channel(p, q, hue), blend_channel(p, q, (hue + 240) % 360)};
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH at cycle %0d, %s: got %h, expected %h", cycle_count, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("pixel_color_key_hsl_recolor verification failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      side_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("unexpected item", rsp_pixel_out, 32'h0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_out !== want.pixel)
                  report_mismatch("pixel_out", rsp_pixel_out, want.pixel);
               if (rsp_recolored !== want.hit)
                  report_mismatch("recolored", 32'(rsp_recolored), 32'(want.hit));
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (idle_enable && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 12);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_pixel(input logic [31:0] pix);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_in <= pix;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      expected_pixels.push_back(predict_recolor(pix));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input reg_index_type idx, input logic [CsrWidth-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      case (idx)
         RegRefColor0, RegRefColor1, RegRefColor2, RegRefColor3: key_ref[idx[1:0]] = data;
         RegRefCount:  key_count = data[2:0];
         RegTargetHue: hue_reg = data[8:0];
         RegTargetSat: sat_reg = data[8:0];
         RegTargetVal: val_reg = data[8:0];
         default: ;
      endcase
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [8:0] pick_level();
      if ($urandom_range(0, 3) == 0)
         return $urandom_range(0, 1) ? 9'd511 : 9'd0;
      return 9'($urandom_range(0, 511));
   endfunction

   function automatic logic [7:0] near_channel(logic [7:0] base);
      return 8'(int'(base) + int'($urandom_range(0, 52)) - 26);
   endfunction

   task automatic test_disabled();
      send_pixel(32'h00000000);
      send_pixel(32'hFFB8F818);
      send_pixel(32'h7F58A858);
      drain_results();
   endtask

   task automatic test_default_window();
      write_csr(RegRefCount, 33'd4);
      send_pixel(32'h12B8F818);
      send_pixel(32'hFF386838);
      drain_results();
      write_csr(RegTargetHue, 33'd489);
      write_csr(RegTargetSat, 33'd230);
      send_pixel(32'h80183818);
      drain_results();
   endtask

   task automatic test_key_match();
      write_csr(RegTargetHue, 33'd0);
      write_csr(RegTargetSat, 33'd256);
      write_csr(RegTargetVal, 33'd256);
      write_csr(RegRefColor1, {9'd128, 24'hC0FF20});
      send_pixel(32'hFFB8F818);
      send_pixel(32'h00C0FF20);
      send_pixel(32'h40D0F818);
      send_pixel(32'h41D1F818);
      send_pixel(32'h55386838);
      send_pixel(32'hAA183818);
      send_pixel(32'h01B8F800);
      send_pixel(32'hFFFFFFFF);
      send_pixel(32'h00000000);
      drain_results();
   endtask

   task automatic test_special_cases();
      write_csr(RegRefCount, 33'd7);
      write_csr(RegTargetSat, 33'd0);
      send_pixel(32'h33183818);
      drain_results();
      write_csr(RegTargetSat, 33'd511);
      send_pixel(32'h44386838);
      drain_results();
      write_csr(RegTargetHue, 33'd359);
      send_pixel(32'h55386838);
      drain_results();
      write_csr(RegTargetVal, 33'd511);
      write_csr(RegRefColor0, {9'd511, 24'hB8F818});
      send_pixel(32'h66B8F818);
      drain_results();
   endtask

   task automatic test_random_phases(input int phases, input int per_phase, input bit idling);
      logic [31:0] pix;
      int          pick;
      for (int ph = 0; ph < phases; ph++) begin
         drain_results();
         idle_enable = idling && (ph % 4 != 3);
         for (int i = 0; i < NumRefs; i++)
            write_csr(reg_index_type'(RegRefColor0 + i), {pick_level(), 24'($urandom())});
         write_csr(RegRefCount, 33'($urandom_range(0, 7)));
         write_csr(RegTargetHue, 33'(pick_level()));
         write_csr(RegTargetSat, 33'(pick_level()));
         write_csr(RegTargetVal, 33'(pick_level()));
         for (int n = 0; n < per_phase; n++) begin
            pix = $urandom();
            if ($urandom_range(0, 4) != 0) begin
               pick = $urandom_range(0, NumRefs - 1);
               pix[23:16] = near_channel(key_ref[pick][23:16]);
               pix[15:8] = near_channel(key_ref[pick][15:8]);
               pix[7:0] = near_channel(key_ref[pick][7:0]);
            end
            send_pixel(pix);
         end
      end
      drain_results();
   endtask

   initial begin
      key_ref[0] = RefReset0;
      key_ref[1] = RefReset1;
      key_ref[2] = RefReset2;
      key_ref[3] = RefReset3;
      key_count = 3'd0;
      hue_reg = 9'd120;
      sat_reg = 9'd204;
      val_reg = 9'd256;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_disabled();
      test_default_window();
      test_key_match();
      test_special_cases();
      test_random_phases(12, 50, 1'b1);
      test_random_phases(2, 50, 1'b0);
      drain_results();
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("pixel_color_key_hsl_recolor verification clean");
      end else begin
         $display("pixel_color_key_hsl_recolor verification failed");
      end
      $finish;
   end

endmodule
